>>> design/rsvm_pkg.sv
// Shared constants, types and helpers for the register-stack VM core.
package rsvm_pkg;

	localparam int MEM_WORDS   = 32768;
	localparam int ADDR_W      = $clog2(MEM_WORDS);
	localparam int WORD_W      = 16;
	localparam int STACK_DEPTH = 4096;
	localparam int STK_AW      = $clog2(STACK_DEPTH);
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);
	localparam int NREGS       = 8;
	localparam int REG_AW      = $clog2(NREGS);

	localparam logic [WORD_W-1:0] REG_FIRST = 16'd32768;
	localparam logic [WORD_W-1:0] REG_LAST  = 16'd32775;
	localparam logic [ADDR_W-1:0] ADDR_MASK = 15'h7FFF;

	localparam logic [WORD_W-1:0] OP_HALT = 16'd0;
	localparam logic [WORD_W-1:0] OP_SET  = 16'd1;
	localparam logic [WORD_W-1:0] OP_PUSH = 16'd2;
	localparam logic [WORD_W-1:0] OP_POP  = 16'd3;
	localparam logic [WORD_W-1:0] OP_EQ   = 16'd4;
	localparam logic [WORD_W-1:0] OP_GT   = 16'd5;
	localparam logic [WORD_W-1:0] OP_JMP  = 16'd6;
	localparam logic [WORD_W-1:0] OP_JT   = 16'd7;
	localparam logic [WORD_W-1:0] OP_JF   = 16'd8;
	localparam logic [WORD_W-1:0] OP_ADD  = 16'd9;
	localparam logic [WORD_W-1:0] OP_MULT = 16'd10;
	localparam logic [WORD_W-1:0] OP_MOD  = 16'd11;
	localparam logic [WORD_W-1:0] OP_AND  = 16'd12;
	localparam logic [WORD_W-1:0] OP_OR   = 16'd13;
	localparam logic [WORD_W-1:0] OP_NOT  = 16'd14;
	localparam logic [WORD_W-1:0] OP_RMEM = 16'd15;
	localparam logic [WORD_W-1:0] OP_WMEM = 16'd16;
	localparam logic [WORD_W-1:0] OP_CALL = 16'd17;
	localparam logic [WORD_W-1:0] OP_RET  = 16'd18;
	localparam logic [WORD_W-1:0] OP_OUT  = 16'd19;
	localparam logic [WORD_W-1:0] OP_IN   = 16'd20;
	localparam logic [WORD_W-1:0] OP_NOOP = 16'd21;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_HALT    = 3'd1,
		ST_UNDER   = 3'd2,
		ST_ILLEGAL = 3'd3,
		ST_OVER    = 3'd4,
		ST_MODZERO = 3'd5,
		ST_WAIT    = 3'd6
	} status_t;

	// Resolve an operand word: literal, register, or zero.
	function automatic logic [WORD_W-1:0] opval(input logic [WORD_W-1:0] w,
			input logic [WORD_W-1:0] rdata, input logic rvalid);
		logic [WORD_W-1:0] v;
		if (w < REG_FIRST) begin
			v = w;
		end else if (w > REG_LAST) begin
			v = '0;
		end else begin
			v = rvalid ? rdata : '0;
		end
		return v;
	endfunction

endpackage

>>> design/rsvm_ram.sv
// Generic simple dual-port RAM with registered read.
module rsvm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> design/rsvm_div.sv
// Restoring remainder unit, one quotient bit per cycle.
module rsvm_div import rsvm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WORD_W-1:0] dividend,
	input  logic [WORD_W-1:0] divisor,
	output logic              done,
	output logic [WORD_W-1:0] rem
);

	localparam int CNT_W = $clog2(WORD_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [WORD_W:0]   r_q;
	logic [WORD_W-1:0] d_q;
	logic [WORD_W-1:0] dvs_q;
	logic [WORD_W:0]   trial;

	assign trial = {r_q[WORD_W-1:0], d_q[WORD_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(WORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q   <= '0;
			d_q   <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			d_q <= {d_q[WORD_W-2:0], 1'b0};
			if (trial >= {1'b0, dvs_q}) begin
				r_q <= trial - {1'b0, dvs_q};
			end else begin
				r_q <= trial;
			end
		end
	end

	assign done = done_q;
	assign rem  = r_q[WORD_W-1:0];

endmodule

>>> design/register_stack_vm_core_unit.sv
// Top level of the register-stack VM core: sequencer, memories and result register.
//
// A small 16-bit processor. Each input beat is either a load (write one program
// word) or an execute (run one instruction); each gives exactly one result beat.
// After reset the core sweeps the 32768-word program memory to zero, one word a
// cycle, and takes no beat until the sweep is done. A load, or an execute while
// the core is stopped, loads the result register as it is taken. An execute
// fetches the opcode and three operand words through the single program memory
// read port, reads registers through the register RAM port, does the data-memory
// and stack reads, and writes back; MOD with a nonzero divisor also waits for the
// bit-serial remainder unit. Only one item is in flight; the next beat is taken
// once the sequencer is idle and the result register is free or being drained.
module register_stack_vm_core_unit import rsvm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              mode,
	input  logic [ADDR_W-1:0] load_address,
	input  logic [WORD_W-1:0] load_data,
	input  logic [WORD_W-1:0] input_char,
	input  logic              input_valid,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        status,
	output logic              output_valid,
	output logic [7:0]        output_char,
	output logic [ADDR_W-1:0] program_counter,
	output logic [WORD_W-1:0] executed_opcode
);

	typedef enum logic [6:0] {
		S_CLR   = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_FETCH = 7'b0000100,
		S_REGRD = 7'b0001000,
		S_EXT   = 7'b0010000,
		S_DIV   = 7'b0100000,
		S_EXEC  = 7'b1000000
	} state_t;

	state_t            state_q;
	logic [2:0]        cnt_q;
	logic [ADDR_W-1:0] clr_q;
	logic [ADDR_W-1:0] ip_q;
	logic [SP_W-1:0]   sp_q;
	logic              halted_q;
	status_t           stop_q;
	logic [WORD_W-1:0] in_char_q;
	logic              in_cvalid_q;
	logic [NREGS-1:0]  reg_valid_q;

	// Fetched words and resolved operand values of the current instruction.
	logic [WORD_W-1:0] opc_q, a_q, b_q, c_q;
	logic [WORD_W-1:0] va_q, vb_q, vc_q;
	logic [WORD_W-1:0] mrd_q, srd_q, rem_q;

	// Result register.
	logic              out_valid_q;
	status_t           status_q;
	logic              ovalid_q;
	logic [7:0]        ochar_q;
	logic [ADDR_W-1:0] pc_q;
	logic [WORD_W-1:0] opc_out_q;

	logic in_fire;
	logic res_load;
	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign in_fire  = in_valid && in_ready;
	// A result is ready as a load or stopped-core beat is taken, or at write-back of an execute.
	assign res_load = (in_fire && (!mode || halted_q)) || (state_q == S_EXEC);

	// ---- memories ----
	logic              pm_we;
	logic [ADDR_W-1:0] pm_waddr, pm_raddr;
	logic [WORD_W-1:0] pm_wdata, pm_rdata;
	logic              rf_we;
	logic [REG_AW-1:0] rf_waddr, rf_raddr;
	logic [WORD_W-1:0] rf_wdata, rf_rdata;
	logic              stk_we;
	logic [STK_AW-1:0] stk_waddr, stk_raddr;
	logic [WORD_W-1:0] stk_wdata, stk_rdata;

	rsvm_ram #(.WIDTH(WORD_W), .DEPTH(MEM_WORDS)) u_pmem (
		.clk(clk), .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata),
		.raddr(pm_raddr), .rdata(pm_rdata)
	);

	rsvm_ram #(.WIDTH(WORD_W), .DEPTH(NREGS)) u_regs (
		.clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
		.raddr(rf_raddr), .rdata(rf_rdata)
	);

	rsvm_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_stack (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.raddr(stk_raddr), .rdata(stk_rdata)
	);

	// ---- remainder unit ----
	logic              div_start;
	logic              div_done;
	logic [WORD_W-1:0] div_rem;

	assign div_start = (state_q == S_EXT) && (cnt_q == 3'd1) && (opc_q == OP_MOD)
		&& (vc_q != '0);

	rsvm_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(vb_q), .divisor(vc_q), .done(div_done), .rem(div_rem)
	);

	// ---- instruction execution (valid in S_EXEC) ----
	logic              dest_ok, st_full, st_empty;
	logic [31:0]       prod;
	logic              ex_stop, ex_rf_we, ex_push, ex_pop, ex_pm_we, ex_ovalid;
	status_t           ex_status;
	logic [WORD_W-1:0] ex_rf_wdata, ex_push_data;
	logic [ADDR_W-1:0] ex_ip;

	assign dest_ok  = (a_q >= REG_FIRST) && (a_q <= REG_LAST);
	assign st_full  = sp_q >= SP_W'(STACK_DEPTH);
	assign st_empty = sp_q == '0;
	assign prod     = vb_q * vc_q;

	always_comb begin
		ex_stop      = 1'b0;
		ex_status    = ST_OK;
		ex_rf_we     = 1'b0;
		ex_rf_wdata  = '0;
		ex_push      = 1'b0;
		ex_pop       = 1'b0;
		ex_push_data = va_q;
		ex_pm_we     = 1'b0;
		ex_ovalid    = 1'b0;
		ex_ip        = ip_q;
		unique case (opc_q)
			OP_HALT: begin
				ex_stop = 1'b1; ex_status = ST_HALT;
			end
			OP_SET: begin
				ex_rf_we = 1'b1; ex_rf_wdata = vb_q; ex_ip = ip_q + ADDR_W'(3);
			end
			OP_PUSH: begin
				if (st_full) begin
					ex_stop = 1'b1; ex_status = ST_OVER;
				end else begin
					ex_push = 1'b1; ex_ip = ip_q + ADDR_W'(2);
				end
			end
			OP_POP: begin
				if (st_empty || st_full && sp_q != SP_W'(STACK_DEPTH)) begin
					ex_stop = 1'b1; ex_status = ST_UNDER;
				end else begin
					ex_pop = 1'b1; ex_rf_we = 1'b1; ex_rf_wdata = srd_q;
					ex_ip = ip_q + ADDR_W'(2);
				end
			end
			OP_EQ: begin
				ex_rf_we = 1'b1; ex_rf_wdata = WORD_W'(vb_q == vc_q);
				ex_ip = ip_q + ADDR_W'(4);
			end
			OP_GT: begin
				ex_rf_we = 1'b1; ex_rf_wdata = WORD_W'(vb_q > vc_q);
				ex_ip = ip_q + ADDR_W'(4);
			end
			OP_JMP: ex_ip = va_q[ADDR_W-1:0];
			OP_JT:  ex_ip = (va_q != '0) ? vb_q[ADDR_W-1:0] : ip_q + ADDR_W'(3);
			OP_JF:  ex_ip = (va_q == '0) ? vb_q[ADDR_W-1:0] : ip_q + ADDR_W'(3);
			OP_ADD: begin
				ex_rf_we = 1'b1;
				ex_rf_wdata = {1'b0, vb_q[ADDR_W-1:0] + vc_q[ADDR_W-1:0]};
				ex_ip = ip_q + ADDR_W'(4);
			end
			OP_MULT: begin
				ex_rf_we = 1'b1; ex_rf_wdata = {1'b0, prod[ADDR_W-1:0]};
				ex_ip = ip_q + ADDR_W'(4);
			end
			OP_MOD: begin
				if (vc_q == '0) begin
					ex_stop = 1'b1; ex_status = ST_MODZERO;
				end else begin
					ex_rf_we = 1'b1; ex_rf_wdata = rem_q; ex_ip = ip_q + ADDR_W'(4);
				end
			end
			OP_AND: begin
				ex_rf_we = 1'b1; ex_rf_wdata = vb_q & vc_q; ex_ip = ip_q + ADDR_W'(4);
			end
			OP_OR: begin
				ex_rf_we = 1'b1; ex_rf_wdata = vb_q | vc_q; ex_ip = ip_q + ADDR_W'(4);
			end
			OP_NOT: begin
				ex_rf_we = 1'b1; ex_rf_wdata = {1'b0, ~vb_q[ADDR_W-1:0]};
				ex_ip = ip_q + ADDR_W'(3);
			end
			OP_RMEM: begin
				ex_rf_we = 1'b1; ex_rf_wdata = mrd_q; ex_ip = ip_q + ADDR_W'(3);
			end
			OP_WMEM: begin
				ex_pm_we = 1'b1; ex_ip = ip_q + ADDR_W'(3);
			end
			OP_CALL: begin
				if (st_full) begin
					ex_stop = 1'b1; ex_status = ST_OVER;
				end else begin
					ex_push = 1'b1;
					ex_push_data = {1'b0, ip_q + ADDR_W'(2)};
					ex_ip = va_q[ADDR_W-1:0];
				end
			end
			OP_RET: begin
				if (st_empty) begin
					ex_stop = 1'b1; ex_status = ST_UNDER;
				end else begin
					ex_pop = 1'b1; ex_ip = srd_q[ADDR_W-1:0];
				end
			end
			OP_OUT: begin
				ex_ovalid = 1'b1; ex_ip = ip_q + ADDR_W'(2);
			end
			OP_IN: begin
				if (!in_cvalid_q) begin
					ex_status = ST_WAIT;
				end else begin
					ex_rf_we = 1'b1; ex_rf_wdata = in_char_q; ex_ip = ip_q + ADDR_W'(2);
				end
			end
			OP_NOOP: ex_ip = ip_q + ADDR_W'(1);
			default: begin
				ex_stop = 1'b1; ex_status = ST_ILLEGAL;
			end
		endcase
	end

	// ---- memory port steering ----
	always_comb begin
		pm_we    = 1'b0;
		pm_waddr = load_address;
		pm_wdata = load_data;
		unique case (state_q)
			S_CLR: begin
				pm_we = 1'b1; pm_waddr = clr_q; pm_wdata = '0;
			end
			S_IDLE: pm_we = in_fire && !mode;
			S_EXEC: begin
				pm_we = ex_pm_we; pm_waddr = va_q[ADDR_W-1:0] & ADDR_MASK; pm_wdata = vb_q;
			end
			default: pm_we = 1'b0;
		endcase
	end

	assign pm_raddr = (state_q == S_EXT) ? vb_q[ADDR_W-1:0] : ip_q + ADDR_W'(cnt_q);

	always_comb begin
		unique case (cnt_q[1:0])
			2'd0:    rf_raddr = a_q[REG_AW-1:0];
			2'd1:    rf_raddr = b_q[REG_AW-1:0];
			default: rf_raddr = c_q[REG_AW-1:0];
		endcase
	end

	assign rf_we     = (state_q == S_EXEC) && ex_rf_we && dest_ok;
	assign rf_waddr  = a_q[REG_AW-1:0];
	assign rf_wdata  = ex_rf_wdata;

	assign stk_raddr = STK_AW'(sp_q - SP_W'(1));
	assign stk_we    = (state_q == S_EXEC) && ex_push;
	assign stk_waddr = sp_q[STK_AW-1:0];
	assign stk_wdata = ex_push_data;

	// ---- sequencer ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			cnt_q       <= '0;
			clr_q       <= '0;
			ip_q        <= '0;
			sp_q        <= '0;
			halted_q    <= 1'b0;
			stop_q      <= ST_OK;
			reg_valid_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Fill the result register on a finished beat; drain it when taken.
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_MASK) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_fire && mode && !halted_q) begin
						state_q <= S_FETCH;
						cnt_q   <= '0;
					end
				end
				S_FETCH: begin
					if (cnt_q == 3'd4) begin
						state_q <= S_REGRD;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				S_REGRD: begin
					if (cnt_q == 3'd3) begin
						state_q <= S_EXT;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				S_EXT: begin
					if (cnt_q == 3'd1) begin
						state_q <= div_start ? S_DIV : S_EXEC;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					ip_q        <= ex_ip;
					state_q     <= S_IDLE;
					if (ex_stop) begin
						halted_q <= 1'b1;
						stop_q   <= ex_status;
					end
					if (ex_push) begin
						sp_q <= sp_q + SP_W'(1);
					end else if (ex_pop) begin
						sp_q <= sp_q - SP_W'(1);
					end
					if (rf_we) begin
						reg_valid_q[rf_waddr] <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---- datapath registers ----
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_fire) begin
			in_char_q   <= input_char;
			in_cvalid_q <= input_valid;
			status_q    <= halted_q ? stop_q : ST_OK;
			ovalid_q    <= 1'b0;
			ochar_q     <= '0;
			pc_q        <= ip_q;
			opc_out_q   <= '0;
		end
		if (state_q == S_FETCH) begin
			unique case (cnt_q)
				3'd1:    opc_q <= pm_rdata;
				3'd2:    a_q   <= pm_rdata;
				3'd3:    b_q   <= pm_rdata;
				3'd4:    c_q   <= pm_rdata;
				default: ;
			endcase
		end
		if (state_q == S_REGRD) begin
			unique case (cnt_q)
				3'd1:    va_q <= opval(a_q, rf_rdata, reg_valid_q[a_q[REG_AW-1:0]]);
				3'd2:    vb_q <= opval(b_q, rf_rdata, reg_valid_q[b_q[REG_AW-1:0]]);
				3'd3:    vc_q <= opval(c_q, rf_rdata, reg_valid_q[c_q[REG_AW-1:0]]);
				default: ;
			endcase
		end
		if (state_q == S_EXT && cnt_q == 3'd1) begin
			mrd_q <= pm_rdata;
			srd_q <= stk_rdata;
		end
		if (div_done) begin
			rem_q <= div_rem;
		end
		if (state_q == S_EXEC) begin
			status_q  <= ex_status;
			ovalid_q  <= ex_ovalid;
			ochar_q   <= ex_ovalid ? va_q[7:0] : 8'd0;
			pc_q      <= ex_ip;
			opc_out_q <= opc_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign output_valid    = ovalid_q;
	assign output_char     = ochar_q;
	assign program_counter = pc_q;
	assign executed_opcode = opc_out_q;

`ifndef NO_ASSERTIONS
	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(STACK_DEPTH))
		else $error("stack pointer beyond depth");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halted flag dropped");

	a_exec_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |-> !out_valid_q)
		else $error("result register still full at write-back");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("remainder unit finished outside divide state");
`endif

endmodule

>>> sim/rsvm_checker.sv
`timescale 1ns / 1ps
// Checker for the VM core: predicts every result beat and compares it with the one seen.
module rsvm_checker import rsvm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic              mode,
	input  logic [ADDR_W-1:0] load_address,
	input  logic [WORD_W-1:0] load_data,
	input  logic [WORD_W-1:0] input_char,
	input  logic              input_valid,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [2:0]        status,
	input  logic              output_valid,
	input  logic [7:0]        output_char,
	input  logic [ADDR_W-1:0] program_counter,
	input  logic [WORD_W-1:0] executed_opcode,
	output int                errors,
	output int                pending
);

	typedef struct packed {
		status_t           st;
		logic              ov;
		logic [7:0]        oc;
		logic [ADDR_W-1:0] pc;
		logic [WORD_W-1:0] op;
	} vm_result_t;

	logic [WORD_W-1:0] mem [MEM_WORDS];
	logic [WORD_W-1:0] regs [NREGS];
	logic [WORD_W-1:0] stk [STACK_DEPTH];
	logic [ADDR_W-1:0] ip;
	int                sp;
	logic              stopped;
	status_t           stop_st;
	vm_result_t        result_q [$];

	function automatic logic [WORD_W-1:0] resolve(input logic [WORD_W-1:0] w);
		if (w < REG_FIRST)
			return w;
		if (w > REG_LAST)
			return '0;
		return regs[w[REG_AW-1:0]];
	endfunction

	task automatic reg_store(input logic [WORD_W-1:0] dst, input logic [WORD_W-1:0] v);
		if (dst >= REG_FIRST && dst <= REG_LAST)
			regs[dst[REG_AW-1:0]] = v;
	endtask

	task automatic run_beat(input logic m, input logic [ADDR_W-1:0] la,
			input logic [WORD_W-1:0] ld, input logic [WORD_W-1:0] ch, input logic iv);
		vm_result_t r;
		logic [ADDR_W-1:0] i1, i2, i3, nip;
		logic [WORD_W-1:0] op, a, b, c, va, vb, vc;
		r = '0;
		r.st = ST_OK;
		if (!m) begin
			mem[la] = ld;
			if (stopped)
				r.st = stop_st;
		end else if (stopped) begin
			r.st = stop_st;
		end else begin
			i1 = ip + 15'd1;
			i2 = ip + 15'd2;
			i3 = ip + 15'd3;
			op = mem[ip];
			a = mem[i1];
			b = mem[i2];
			c = mem[i3];
			va = resolve(a);
			vb = resolve(b);
			vc = resolve(c);
			r.op = op;
			nip = ip;
			case (op)
				OP_HALT: r.st = ST_HALT;
				OP_SET: begin reg_store(a, vb); nip = i3; end
				OP_PUSH: begin
					if (sp >= STACK_DEPTH) begin
						r.st = ST_OVER;
					end else begin
						stk[sp] = va;
						sp++;
						nip = i2;
					end
				end
				OP_POP: begin
					if (sp == 0) begin
						r.st = ST_UNDER;
					end else begin
						sp--;
						reg_store(a, stk[sp]);
						nip = i2;
					end
				end
				OP_EQ: begin reg_store(a, (vb == vc) ? 16'd1 : 16'd0); nip = ip + 15'd4; end
				OP_GT: begin reg_store(a, (vb > vc) ? 16'd1 : 16'd0); nip = ip + 15'd4; end
				OP_JMP: nip = va[ADDR_W-1:0];
				OP_JT: nip = (va != 0) ? vb[ADDR_W-1:0] : i3;
				OP_JF: nip = (va == 0) ? vb[ADDR_W-1:0] : i3;
				OP_ADD: begin reg_store(a, (vb + vc) & 16'h7FFF); nip = ip + 15'd4; end
				OP_MULT: begin reg_store(a, (vb * vc) & 16'h7FFF); nip = ip + 15'd4; end
				OP_MOD: begin
					if (vc == 0) begin
						r.st = ST_MODZERO;
					end else begin
						reg_store(a, vb % vc);
						nip = ip + 15'd4;
					end
				end
				OP_AND: begin reg_store(a, vb & vc); nip = ip + 15'd4; end
				OP_OR: begin reg_store(a, vb | vc); nip = ip + 15'd4; end
				OP_NOT: begin reg_store(a, ~vb & 16'h7FFF); nip = i3; end
				OP_RMEM: begin reg_store(a, mem[vb[ADDR_W-1:0]]); nip = i3; end
				OP_WMEM: begin mem[va[ADDR_W-1:0]] = vb; nip = i3; end
				OP_CALL: begin
					if (sp >= STACK_DEPTH) begin
						r.st = ST_OVER;
					end else begin
						stk[sp] = {1'b0, i2};
						sp++;
						nip = va[ADDR_W-1:0];
					end
				end
				OP_RET: begin
					if (sp == 0) begin
						r.st = ST_UNDER;
					end else begin
						sp--;
						nip = stk[sp][ADDR_W-1:0];
					end
				end
				OP_OUT: begin r.ov = 1'b1; r.oc = va[7:0]; nip = i2; end
				OP_IN: begin
					if (!iv) begin
						r.st = ST_WAIT;
					end else begin
						reg_store(a, ch);
						nip = i2;
					end
				end
				OP_NOOP: nip = i1;
				default: r.st = ST_ILLEGAL;
			endcase
			if (r.st != ST_OK && r.st != ST_WAIT) begin
				stopped = 1'b1;
				stop_st = r.st;
			end
			ip = nip;
		end
		r.pc = ip;
		result_q.insert(result_q.size(), r);
	endtask

	task automatic compare(input string name, input int unsigned e, input int unsigned a);
		if (e != a) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $realtime, name, e, a);
			errors++;
		end
	endtask

	initial begin
		errors = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		vm_result_t e;
		if (!arst_n) begin
			for (int i = 0; i < MEM_WORDS; i++)
				mem[i] = '0;
			for (int i = 0; i < NREGS; i++)
				regs[i] = '0;
			ip = '0;
			sp = 0;
			stopped = 1'b0;
			stop_st = ST_OK;
			result_q.delete();
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					$display("%0t: result beat with nothing expected, expected none actual pc %0d",
						$realtime, program_counter);
					errors++;
				end else begin
					e = result_q.pop_front();
					compare("status", e.st, status);
					compare("output_valid", e.ov, output_valid);
					compare("output_char", e.oc, output_char);
					compare("program_counter", e.pc, program_counter);
					compare("executed_opcode", e.op, executed_opcode);
				end
			end
			if (in_valid && in_ready)
				run_beat(mode, load_address, load_data, input_char, input_valid);
			pending <= result_q.size();
		end
	end

endmodule

>>> sim/register_stack_vm_core_unit_test.sv
`timescale 1ns / 1ps
// Testbench top for the VM core: builds programs word by word, steps them and gives the verdict.
module register_stack_vm_core_unit_test;
	import rsvm_pkg::*;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              mode = 1'b0;
	logic [ADDR_W-1:0] load_address = '0;
	logic [WORD_W-1:0] load_data = '0;
	logic [WORD_W-1:0] input_char = '0;
	logic              input_valid = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [2:0]        status;
	logic              output_valid;
	logic [7:0]        output_char;
	logic [ADDR_W-1:0] program_counter;
	logic [WORD_W-1:0] executed_opcode;
	int                err_count;
	int                pending;

	// Knobs for the sender and the receiver.
	int   gap_pct = 16;
	int   stall_pct = 16;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int   hold_cnt = 0;

	// Shadow of the control flow, just enough to place each instruction where it runs.
	// Stack entries hold the known return value, or -1 when it came from a register.
	logic [ADDR_W-1:0] ip;
	int                ret_stk [$];
	int                beats = 0;

	register_stack_vm_core_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .load_address(load_address), .load_data(load_data),
		.input_char(input_char), .input_valid(input_valid),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .output_valid(output_valid), .output_char(output_char),
		.program_counter(program_counter), .executed_opcode(executed_opcode)
	);

	rsvm_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .load_address(load_address), .load_data(load_data),
		.input_char(input_char), .input_valid(input_valid),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .output_valid(output_valid), .output_char(output_char),
		.program_counter(program_counter), .executed_opcode(executed_opcode),
		.errors(err_count), .pending(pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Receiver: random stalls, plus one long hold-off on request so the core backs up.
	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			out_ready <= 1'b0;
			hold_cnt <= hold_cnt + 1;
			if (hold_cnt == 400)
				hold_done <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Offer one beat and hold it until the core takes it; idle first at random.
	task automatic send_beat(input logic m, input logic [ADDR_W-1:0] la,
			input logic [WORD_W-1:0] ld, input logic [WORD_W-1:0] ch, input logic iv);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		load_address <= la;
		load_data <= ld;
		input_char <= ch;
		input_valid <= iv;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		beats++;
	endtask

	task automatic load_word(input logic [ADDR_W-1:0] addr, input logic [WORD_W-1:0] data);
		send_beat(1'b0, addr, data, WORD_W'($urandom), 1'($urandom));
	endtask

	task automatic exec_beat(input logic [WORD_W-1:0] ch, input logic iv);
		send_beat(1'b1, ADDR_W'($urandom), WORD_W'($urandom), ch, iv);
	endtask

	function automatic int op_len(input logic [WORD_W-1:0] op);
		case (op)
			OP_HALT, OP_RET, OP_NOOP: return 1;
			OP_PUSH, OP_POP, OP_JMP, OP_CALL, OP_OUT, OP_IN: return 2;
			OP_SET, OP_JT, OP_JF, OP_NOT, OP_RMEM, OP_WMEM: return 3;
			OP_EQ, OP_GT, OP_ADD, OP_MULT, OP_MOD, OP_AND, OP_OR: return 4;
			default: return 1;
		endcase
	endfunction

	// Value of an operand that names no register; registers count as zero here.
	function automatic logic [WORD_W-1:0] lit(input logic [WORD_W-1:0] w);
		return (w < REG_FIRST) ? w : '0;
	endfunction

	function automatic logic [WORD_W-1:0] any_opnd();
		int r;
		r = $urandom_range(9);
		if (r < 4)
			return REG_FIRST + WORD_W'($urandom_range(NREGS - 1));
		if (r < 6)
			return WORD_W'($urandom_range(3));
		if (r == 6)
			return WORD_W'($urandom_range(32776, 65535));
		return WORD_W'($urandom_range(65535));
	endfunction

	function automatic logic [WORD_W-1:0] plain_opnd();
		logic [WORD_W-1:0] w;
		if ($urandom_range(99) < 15)
			return WORD_W'($urandom_range(32764, 32767));
		do
			w = WORD_W'($urandom_range(65535));
		while (w >= REG_FIRST && w <= REG_LAST);
		return w;
	endfunction

	function automatic logic [WORD_W-1:0] dest_opnd();
		if ($urandom_range(99) < 85)
			return REG_FIRST + WORD_W'($urandom_range(NREGS - 1));
		return WORD_W'($urandom_range(65535));
	endfunction

	// Place one instruction at the shadow pointer, step it, and advance the shadow.
	task automatic run_instr(input logic [WORD_W-1:0] op, input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b, input logic [WORD_W-1:0] c,
			input logic [WORD_W-1:0] ch, input logic iv);
		logic [WORD_W-1:0] words [4];
		int n, v;
		words = '{op, a, b, c};
		n = op_len(op);
		for (int k = 0; k < n; k++)
			load_word(ip + ADDR_W'(k), words[k]);
		exec_beat(ch, iv);
		case (op)
			OP_HALT: ;
			OP_JMP: ip = ADDR_W'(lit(a));
			OP_JT: ip = (lit(a) != 0) ? ADDR_W'(lit(b)) : ip + 15'd3;
			OP_JF: ip = (lit(a) == 0) ? ADDR_W'(lit(b)) : ip + 15'd3;
			OP_CALL: begin
				ret_stk.insert(ret_stk.size(), int'(ip + 15'd2));
				ip = ADDR_W'(lit(a));
			end
			OP_RET: begin
				v = ret_stk.pop_back();
				ip = v[ADDR_W-1:0];
			end
			OP_PUSH: begin
				ret_stk.insert(ret_stk.size(),
					(a >= REG_FIRST && a <= REG_LAST) ? -1 : int'(lit(a)));
				ip = ip + 15'd2;
			end
			OP_POP: begin
				void'(ret_stk.pop_back());
				ip = ip + 15'd2;
			end
			OP_IN: if (iv) ip = ip + 15'd2;
			OP_MOD: if (c != 0) ip = ip + 15'd4;
			default: if (op <= OP_NOOP) ip = ip + ADDR_W'(n);
		endcase
	endtask

	// A random instruction whose control flow stays predictable and that never stops the core.
	task automatic rand_instr();
		logic [WORD_W-1:0] op, a, b, c;
		op = WORD_W'($urandom_range(OP_SET, OP_NOOP));
		if (op == OP_RET && (ret_stk.size() == 0 || ret_stk[$] < 0))
			op = OP_NOOP;
		if (op == OP_POP && ret_stk.size() == 0)
			op = OP_PUSH;
		if ((op == OP_PUSH || op == OP_CALL) && ret_stk.size() >= 48)
			op = OP_POP;
		a = dest_opnd();
		b = any_opnd();
		c = any_opnd();
		case (op)
			OP_PUSH, OP_OUT, OP_WMEM: a = any_opnd();
			OP_JMP, OP_CALL: a = plain_opnd();
			OP_JT, OP_JF: begin
				// A register condition jumps to the fall-through address either way.
				if ($urandom_range(1)) begin
					a = any_opnd();
					b = {1'b0, ip + 15'd3};
				end else begin
					a = plain_opnd();
					b = plain_opnd();
				end
			end
			OP_MOD: c = WORD_W'($urandom_range(1, 32767));
			default: ;
		endcase
		run_instr(op, a, b, c, WORD_W'($urandom), $urandom_range(3) != 0);
	endtask

	// Drive the core into one of its stopping cases, chosen at random per run.
	task automatic stop_core();
		logic [WORD_W-1:0] op;
		case ($urandom_range(3))
			0: run_instr(OP_HALT, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
			1: begin
				op = WORD_W'($urandom_range(OP_NOOP + 1, 65535));
				run_instr(op, any_opnd(), any_opnd(), any_opnd(), 16'd0, 1'b0);
			end
			2: begin
				while (ret_stk.size() > 0)
					run_instr(OP_POP, dest_opnd(), 16'd0, 16'd0, 16'd0, 1'b0);
				if ($urandom_range(1))
					run_instr(OP_RET, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
				else
					run_instr(OP_POP, dest_opnd(), 16'd0, 16'd0, 16'd0, 1'b0);
			end
			default: run_instr(OP_MOD, dest_opnd(), any_opnd(), 16'd0, 16'd0, 1'b0);
		endcase
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, wide values, bad destination, waiting input, wrap.
		load_word(15'h7FFF, 16'hFFFF);
		ip = '0;
		run_instr(OP_SET, REG_FIRST, 16'd32767, 16'd0, 16'd0, 1'b0);
		run_instr(OP_ADD, REG_FIRST + 16'd1, REG_FIRST, REG_LAST, 16'd0, 1'b0);
		run_instr(OP_SET, 16'd32776, 16'hFFFF, 16'd0, 16'd0, 1'b0);
		run_instr(OP_IN, REG_LAST, 16'd0, 16'd0, 16'hFFFF, 1'b0);
		run_instr(OP_IN, REG_LAST, 16'd0, 16'd0, 16'hFFFF, 1'b1);
		run_instr(OP_OUT, REG_LAST, 16'd0, 16'd0, 16'd0, 1'b0);
		run_instr(OP_JMP, 16'd32766, 16'd0, 16'd0, 16'd0, 1'b0);
		run_instr(OP_NOT, REG_FIRST + 16'd2, REG_LAST, 16'd0, 16'd0, 1'b0);

		// Random programs with a little noise, pressure points along the way.
		while (beats < 780) begin
			if (beats > 300 && !hold_req)
				hold_req = 1'b1;
			if (beats > 450 && beats < 470) begin
				// Pause the sender until the core has drained.
				in_valid <= 1'b0;
				@(posedge clk);
				while (pending != 0)
					@(posedge clk);
			end
			if (beats > 550 && beats < 700) begin
				gap_pct = 0;
				stall_pct = 0;
			end else begin
				gap_pct = 16;
				stall_pct = 16;
			end
			if ($urandom_range(99) < 10)
				load_word(ADDR_W'($urandom), WORD_W'($urandom));
			else
				rand_instr();
		end

		// Stop the core, then check that it stays stopped while loads still land.
		stop_core();
		repeat (6) begin
			exec_beat(WORD_W'($urandom), 1'($urandom));
			load_word(ADDR_W'($urandom), WORD_W'($urandom));
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (err_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#20ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule
